// ===== design/dip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double_integer_power block.
// Used by dip_fpu, dip_dpath, dip_ctrl and the top level; depends on nothing.
package dip_pkg;

    localparam int IN_W  = 96;
    localparam int OUT_W = 64;

    localparam logic [63:0] C_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] C_PINF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] C_QNAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    // operation of the shared arithmetic unit
    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } t_fop;

    // operand selection for the arithmetic unit
    typedef enum logic [1:0] {
        F_MUL_ACC,
        F_MUL_SQ,
        F_RECIP
    } t_fsel;

    typedef struct packed {
        logic  set_special;
        logic  start;
        t_fsel fsel;
        logic  wr_acc;
        logic  wr_x;
        logic  x_inf;
        logic  shift_mag;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic neg;
        logic base_zero;
        logic mag_lsb;
        logic mag_last;
        logic fpu_done;
        logic out_free;
    } t_sts;

endpackage

// ===== design/double_integer_power.sv =====
`timescale 1ns / 1ps
// One item at a time: a new item is not taken until the previous result moves to the
// output register. An item is classified, then for a negative exponent the base is
// replaced by its reciprocal, then square-and-multiply runs over the exponent bits on
// the shared binary64 unit, which normalises subnormals in a loop; special bases skip it.
// A finished result waits in the output register until it is taken.
// Synchronous active-low reset clears the control state; payload registers are not reset.
module double_integer_power (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [dip_pkg::IN_W-1:0] i_s_axis_tdata,  // [63:0] base_bits, [95:64] exponent
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [dip_pkg::OUT_W-1:0] o_m_axis_tdata  // [63:0] result_bits
);

    logic          w_accept;
    logic          w_ready;
    dip_pkg::t_cmd w_cmd;
    dip_pkg::t_sts w_sts;

    assign w_accept        = i_s_axis_tvalid && w_ready;
    assign o_s_axis_tready = w_ready;

    dip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    dip_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_base_bits   (i_s_axis_tdata[63:0]),
        .i_exponent    (i_s_axis_tdata[95:64]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_result_bits (o_m_axis_tdata)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("second item taken while one in flight");

endmodule

// ===== design/dip_fpu.sv =====
`timescale 1ns / 1ps
// Multi-cycle binary64 unit: round-to-nearest-even multiply and reciprocal.
// Depends on dip_pkg.
module dip_fpu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dip_pkg::t_fop i_op,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [63:0]   o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PP,
        S_DIVN,
        S_DIV,
        S_NORM,
        S_ROUND,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [105:0]       r_p;
    logic signed [12:0] r_e;
    logic               r_sign;
    logic [52:0]        r_ma;
    logic [52:0]        r_mb;
    logic [5:0]         r_cnt;
    logic [53:0]        r_pp;
    logic [53:0]        r_rem;
    logic [55:0]        r_q;
    logic [63:0]        r_res;

    logic [10:0] w_eaf, w_ebf;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_a_zero, w_b_zero;
    logic [26:0] w_opa, w_opb;
    logic [53:0] w_prod;
    logic [6:0]  w_sh;
    logic        w_ge;
    logic [53:0] w_diff, n_rem;
    logic [55:0] n_q;
    logic [10:0] w_efield;
    logic        w_rnd;
    logic [62:0] w_sum;

    assign w_eaf    = i_a[62:52];
    assign w_ebf    = i_b[62:52];
    assign w_a_nan  = (w_eaf == dip_pkg::EXP_MAX) && (i_a[51:0] != '0);
    assign w_b_nan  = (w_ebf == dip_pkg::EXP_MAX) && (i_b[51:0] != '0);
    assign w_a_inf  = (w_eaf == dip_pkg::EXP_MAX) && (i_a[51:0] == '0);
    assign w_b_inf  = (w_ebf == dip_pkg::EXP_MAX) && (i_b[51:0] == '0);
    assign w_a_zero = (i_a[62:0] == '0);
    assign w_b_zero = (i_b[62:0] == '0);

    // partial products, high/low halves in the order hh, hl, lh, ll
    assign w_opa  = r_cnt[1] ? {1'b0, r_ma[25:0]} : r_ma[52:26];
    assign w_opb  = r_cnt[0] ? {1'b0, r_mb[25:0]} : r_mb[52:26];
    assign w_prod = w_opa * w_opb;

    always_comb begin
        case (r_cnt[2:0])
            3'd1:    w_sh = 7'd52;
            3'd2:    w_sh = 7'd26;
            3'd3:    w_sh = 7'd26;
            default: w_sh = 7'd0;
        endcase
    end

    assign w_diff = r_rem - {1'b0, r_mb};
    assign w_ge   = (r_rem >= {1'b0, r_mb});
    assign n_rem  = w_ge ? {w_diff[52:0], 1'b0} : {r_rem[52:0], 1'b0};
    assign n_q    = {r_q[54:0], w_ge};

    assign w_efield = r_p[105] ? r_e[10:0] : 11'd0;
    assign w_rnd    = r_p[52] & ((|r_p[51:0]) | r_p[53]);
    assign w_sum    = {w_efield, r_p[104:53]} + 63'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cnt <= '0;
                        r_p   <= '0;
                        if (i_op == dip_pkg::OP_RECIP) begin
                            r_sign  <= i_a[63];
                            r_mb    <= {w_eaf != 11'd0, i_a[51:0]};
                            r_e     <= (w_eaf == 11'd0) ? 13'sd1 : $signed({2'b00, w_eaf});
                            r_state <= S_DIVN;
                        end else begin
                            r_sign <= i_a[63] ^ i_b[63];
                            r_ma   <= {w_eaf != 11'd0, i_a[51:0]};
                            r_mb   <= {w_ebf != 11'd0, i_b[51:0]};
                            r_e    <= $signed({2'b00, (w_eaf == 11'd0) ? 11'd1 : w_eaf})
                                    + $signed({2'b00, (w_ebf == 11'd0) ? 11'd1 : w_ebf})
                                    - 13'sd1022;
                            if (w_a_nan) begin
                                r_res   <= i_a | 64'h0008_0000_0000_0000;
                                r_state <= S_DONE;
                            end else if (w_b_nan) begin
                                r_res   <= i_b | 64'h0008_0000_0000_0000;
                                r_state <= S_DONE;
                            end else if ((w_a_inf && w_b_zero) || (w_b_inf && w_a_zero)) begin
                                r_res   <= dip_pkg::C_QNAN;
                                r_state <= S_DONE;
                            end else if (w_a_inf || w_b_inf) begin
                                r_res   <= {i_a[63] ^ i_b[63], dip_pkg::C_PINF[62:0]};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_PP;
                            end
                        end
                    end
                end
                S_PP: begin
                    if (r_cnt < 6'd4) begin
                        r_pp <= w_prod;
                    end
                    if (r_cnt != 6'd0) begin
                        r_p <= r_p + (106'(r_pp) << w_sh);
                    end
                    if (r_cnt == 6'd4) begin
                        r_state <= S_NORM;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIVN: begin
                    // bring a subnormal divisor up to a leading one
                    if (r_mb[52]) begin
                        r_e     <= 13'sd2046 - r_e;
                        r_rem   <= {2'b01, 52'd0};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_mb <= {r_mb[51:0], 1'b0};
                        r_e  <= r_e - 13'sd1;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd55) begin
                        r_p     <= {n_q, 49'd0, |n_rem};
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_p == '0 || r_e < -13'sd53) begin
                        r_res   <= {r_sign, 63'd0};
                        r_state <= S_DONE;
                    end else if (r_e < 13'sd1) begin
                        // shift right, jamming lost bits into the sticky position
                        r_p <= {1'b0, r_p[105:2], r_p[1] | r_p[0]};
                        r_e <= r_e + 13'sd1;
                    end else if (!r_p[105] && r_e > 13'sd1) begin
                        r_p <= {r_p[104:0], 1'b0};
                        r_e <= r_e - 13'sd1;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_e >= 13'sd2047) begin
                        r_res <= {r_sign, dip_pkg::C_PINF[62:0]};
                    end else begin
                        r_res <= {r_sign, w_sum};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start while unit busy");

    a_round_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_p[105] || r_e == 13'sd1))
        else $error("rounding an unnormalised product");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");

endmodule

// ===== design/dip_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: base, exponent magnitude, running power and accumulator registers,
// special-case values and the output register. Depends on dip_pkg, dip_fpu.
module dip_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [63:0]   i_base_bits,
    input  logic [31:0]   i_exponent,
    input  dip_pkg::t_cmd i_cmd,
    output dip_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [63:0]   o_result_bits
);

    logic [63:0] r_base;
    logic [31:0] r_exp;
    logic [31:0] r_mag;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_out;
    logic        r_ovalid;

    logic          w_nan, w_inf;
    logic [63:0]   w_special;
    dip_pkg::t_fop w_op;
    logic [63:0]   w_fa, w_fb;
    logic          w_fdone;
    logic [63:0]   w_fres;

    assign w_nan = (r_base[62:52] == dip_pkg::EXP_MAX) && (r_base[51:0] != '0);
    assign w_inf = (r_base[62:52] == dip_pkg::EXP_MAX) && (r_base[51:0] == '0);

    always_comb begin
        if (w_nan) begin
            w_special = r_base;
        end else if (r_exp == '0) begin
            w_special = dip_pkg::C_ONE;
        end else if (r_exp[31]) begin
            w_special = '0;
        end else if (r_base[63] && r_exp[0]) begin
            w_special = {1'b1, dip_pkg::C_PINF[62:0]};
        end else begin
            w_special = dip_pkg::C_PINF;
        end
    end

    always_comb begin
        case (i_cmd.fsel)
            dip_pkg::F_MUL_ACC: begin
                w_op = dip_pkg::OP_MUL;
                w_fa = r_acc;
                w_fb = r_x;
            end
            dip_pkg::F_MUL_SQ: begin
                w_op = dip_pkg::OP_MUL;
                w_fa = r_x;
                w_fb = r_x;
            end
            default: begin
                w_op = dip_pkg::OP_RECIP;
                w_fa = r_x;
                w_fb = r_x;
            end
        endcase
    end

    dip_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (w_op),
        .i_a     (w_fa),
        .i_b     (w_fb),
        .o_done  (w_fdone),
        .o_res   (w_fres)
    );

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base <= i_base_bits;
            r_exp  <= i_exponent;
            r_mag  <= i_exponent[31] ? (32'd0 - i_exponent) : i_exponent;
            r_x    <= i_base_bits;
            r_acc  <= dip_pkg::C_ONE;
        end else begin
            if (i_cmd.set_special) begin
                r_acc <= w_special;
            end
            if (i_cmd.wr_acc) begin
                r_acc <= w_fres;
            end
            if (i_cmd.wr_x) begin
                r_x <= w_fres;
            end
            if (i_cmd.x_inf) begin
                // reciprocal of a signed zero
                r_x <= {r_base[63], dip_pkg::C_PINF[62:0]};
            end
            if (i_cmd.shift_mag) begin
                r_mag <= {1'b0, r_mag[31:1]};
            end
        end
        if (i_cmd.emit) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.special   = w_nan || w_inf || (r_exp == '0);
    assign o_sts.neg       = r_exp[31];
    assign o_sts.base_zero = (r_base[62:0] == '0);
    assign o_sts.mag_lsb   = r_mag[0];
    assign o_sts.mag_last  = (r_mag[31:1] == '0);
    assign o_sts.fpu_done  = w_fdone;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_result_bits = r_out;

endmodule

// ===== design/dip_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences classification, reciprocal and square-and-multiply
// steps over the datapath. Depends on dip_pkg.
module dip_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  dip_pkg::t_sts i_sts,
    output dip_pkg::t_cmd o_cmd,
    output logic          o_ready
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_CLASS,
        C_RECIP,
        C_LOOP,
        C_MUL,
        C_STEP,
        C_SQ,
        C_DONE
    } t_state;

    t_state        r_state;
    dip_pkg::t_cmd r_cmd;
    logic          r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cmd   <= '0;
            r_ready <= 1'b1;
        end else begin
            r_cmd.set_special <= 1'b0;
            r_cmd.start       <= 1'b0;
            r_cmd.wr_acc      <= 1'b0;
            r_cmd.wr_x        <= 1'b0;
            r_cmd.x_inf       <= 1'b0;
            r_cmd.shift_mag   <= 1'b0;
            r_cmd.emit        <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_accept) begin
                        r_ready <= 1'b0;
                        r_state <= C_CLASS;
                    end
                end
                C_CLASS: begin
                    if (i_sts.special) begin
                        r_cmd.set_special <= 1'b1;
                        r_state           <= C_DONE;
                    end else if (i_sts.neg && i_sts.base_zero) begin
                        r_cmd.x_inf <= 1'b1;
                        r_state     <= C_LOOP;
                    end else if (i_sts.neg) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.fsel  <= dip_pkg::F_RECIP;
                        r_state     <= C_RECIP;
                    end else begin
                        r_state <= C_LOOP;
                    end
                end
                C_RECIP: begin
                    if (i_sts.fpu_done) begin
                        r_cmd.wr_x <= 1'b1;
                        r_state    <= C_LOOP;
                    end
                end
                C_LOOP: begin
                    if (i_sts.mag_lsb) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.fsel  <= dip_pkg::F_MUL_ACC;
                        r_state     <= C_MUL;
                    end else begin
                        r_state <= C_STEP;
                    end
                end
                C_MUL: begin
                    if (i_sts.fpu_done) begin
                        r_cmd.wr_acc <= 1'b1;
                        r_state      <= C_STEP;
                    end
                end
                C_STEP: begin
                    if (i_sts.mag_last) begin
                        r_state <= C_DONE;
                    end else begin
                        r_cmd.shift_mag <= 1'b1;
                        r_cmd.start     <= 1'b1;
                        r_cmd.fsel      <= dip_pkg::F_MUL_SQ;
                        r_state         <= C_SQ;
                    end
                end
                C_SQ: begin
                    if (i_sts.fpu_done) begin
                        r_cmd.wr_x <= 1'b1;
                        r_state    <= C_LOOP;
                    end
                end
                C_DONE: begin
                    // hold until the output register has room
                    if (i_sts.out_free) begin
                        r_cmd.emit <= 1'b1;
                        r_ready    <= 1'b1;
                        r_state    <= C_IDLE;
                    end
                end
                default: begin
                    r_ready <= 1'b1;
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_cmd   = r_cmd;
    assign o_ready = r_ready;

endmodule
